// ----- rtl/tsc_pkg.sv -----
// tsc_pkg: shared types and constants for the tcp segment checker
// used by every module of the block; depends on nothing

package tsc_pkg;

   // fixed tcp header length, byte counter limits and the tcp protocol number
   localparam int unsigned HEADER_LEN  = 20;
   localparam int unsigned CNT_W       = 17;
   localparam logic [CNT_W-1:0] COUNT_MAX     = 17'h10000;
   localparam logic [CNT_W-1:0] COUNT_MAX_M1  = 17'h0FFFF;
   localparam logic [CNT_W-1:0] CAPTURE_END   = 17'd18;
   localparam logic [15:0]      IP_PROTO_TCP  = 16'd6;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_BAD_CKSUM = 2'd2;

   // configuration register indexes
   localparam logic [7:0] CSR_SRC_ADDR = 8'd0;
   localparam logic [7:0] CSR_DST_ADDR = 8'd1;

   // header byte positions
   localparam logic [4:0] POS_SRC_HI  = 5'd0;
   localparam logic [4:0] POS_SRC_LO  = 5'd1;
   localparam logic [4:0] POS_DST_HI  = 5'd2;
   localparam logic [4:0] POS_DST_LO  = 5'd3;
   localparam logic [4:0] POS_SEQ_0   = 5'd4;
   localparam logic [4:0] POS_SEQ_3   = 5'd7;
   localparam logic [4:0] POS_ACK_0   = 5'd8;
   localparam logic [4:0] POS_ACK_3   = 5'd11;
   localparam logic [4:0] POS_OFFSET  = 5'd12;
   localparam logic [4:0] POS_FLAGS   = 5'd13;
   localparam logic [4:0] POS_WIN_HI  = 5'd14;
   localparam logic [4:0] POS_WIN_LO  = 5'd15;
   localparam logic [4:0] POS_CKS_HI  = 5'd16;
   localparam logic [4:0] POS_CKS_LO  = 5'd17;

   // one finished segment, handed from the parser to the checker
   typedef struct packed {
      logic [15:0]      source_port;
      logic [15:0]      destination_port;
      logic [31:0]      seq_number;
      logic [31:0]      ack_number;
      logic [3:0]       offset_words;
      logic [7:0]       flag_bits;
      logic [15:0]      window;
      logic [15:0]      received_checksum;
      logic [15:0]      data_sum;
      logic [CNT_W-1:0] length;
      logic             overflow;
   } seg_rec_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      if (s[16]) begin
         oc_add = s[15:0] + 16'd1;
      end else begin
         oc_add = s[15:0];
      end
   endfunction

endpackage

// ----- rtl/tsc_front.sv -----
// tsc_front: byte-serial parser, captures header fields, counts length, sums data
// depends on tsc_pkg; pushes one record per segment into tsc_queue

module tsc_front
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        q_full,
   output logic        q_push,
   output seg_rec_type q_rec
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       pend_ff, pend_in;
   logic [15:0]      src_ff, src_in;
   logic [15:0]      dst_ff, dst_in;
   logic [31:0]      seq_ff, seq_in;
   logic [31:0]      ack_ff, ack_in;
   logic [3:0]       off_ff, off_in;
   logic [7:0]       flg_ff, flg_in;
   logic [15:0]      win_ff, win_in;
   logic [15:0]      cks_ff, cks_in;
   logic             ovf_ff, ovf_in;

   logic             beat;
   logic             odd_pos;
   logic [15:0]      word;
   logic [15:0]      sum_upd;

   assign req_ready = !q_full;
   assign beat      = req_valid && req_ready;
   assign odd_pos   = count_ff[0];

   // odd byte closes a 16-bit word, an even last byte is padded with zero
   assign word    = odd_pos ? {pend_ff, req_data_byte} : {req_data_byte, 8'h00};
   assign sum_upd = oc_add(sum_ff, word);

   // field capture and per-byte accounting
   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      seq_in = seq_ff;
      ack_in = ack_ff;
      off_in = off_ff;
      flg_in = flg_ff;
      win_in = win_ff;
      cks_in = cks_ff;
      if (count_ff < CAPTURE_END) begin
         case (count_ff[4:0])
            POS_SRC_HI, POS_SRC_LO: src_in = {src_ff[7:0], req_data_byte};
            POS_DST_HI, POS_DST_LO: dst_in = {dst_ff[7:0], req_data_byte};
            POS_OFFSET:             off_in = req_data_byte[7:4];
            POS_FLAGS:              flg_in = req_data_byte;
            POS_WIN_HI, POS_WIN_LO: win_in = {win_ff[7:0], req_data_byte};
            POS_CKS_HI, POS_CKS_LO: cks_in = {cks_ff[7:0], req_data_byte};
            default: begin
               if (count_ff[4:0] >= POS_SEQ_0 && count_ff[4:0] <= POS_SEQ_3) begin
                  seq_in = {seq_ff[23:0], req_data_byte};
               end else if (count_ff[4:0] >= POS_ACK_0 && count_ff[4:0] <= POS_ACK_3) begin
                  ack_in = {ack_ff[23:0], req_data_byte};
               end
            end
         endcase
      end

      // saturating length count
      if (count_ff >= COUNT_MAX_M1) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = count_ff + 17'd1;
      end
      ovf_in = ovf_ff || (count_in == COUNT_MAX);

      if (odd_pos) begin
         sum_in  = sum_upd;
         pend_in = pend_ff;
      end else begin
         sum_in  = sum_ff;
         pend_in = req_data_byte;
      end
   end

   // record of the finished segment, taken on the last beat
   always_comb begin
      q_push                   = beat && req_last_byte;
      q_rec.source_port        = src_in;
      q_rec.destination_port   = dst_in;
      q_rec.seq_number         = seq_in;
      q_rec.ack_number         = ack_in;
      q_rec.offset_words       = off_in;
      q_rec.flag_bits          = flg_in;
      q_rec.window             = win_in;
      q_rec.received_checksum  = cks_in;
      q_rec.data_sum           = sum_upd;
      q_rec.length             = count_in;
      q_rec.overflow           = ovf_in;
   end

   // segment state, cleared after each last beat
   always_ff @(posedge clock) begin
      if (reset || (beat && req_last_byte)) begin
         count_ff <= '0;
         sum_ff   <= '0;
         pend_ff  <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         seq_ff   <= '0;
         ack_ff   <= '0;
         off_ff   <= '0;
         flg_ff   <= '0;
         win_ff   <= '0;
         cks_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (beat) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         seq_ff   <= seq_in;
         ack_ff   <= ack_in;
         off_ff   <= off_in;
         flg_ff   <= flg_in;
         win_ff   <= win_in;
         cks_ff   <= cks_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- rtl/tsc_queue.sv -----
// tsc_queue: two-entry queue of segment records between parser and checker
// depends on tsc_pkg for the record type

module tsc_queue
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  seg_rec_type wr_rec,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output seg_rec_type rd_rec
);

   seg_rec_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign rd_rec    = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // record storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_rec;
      end
   end

endmodule

// ----- rtl/tsc_back.sv -----
// tsc_back: checksum verify against the pseudo-header, length checks, result register
// depends on tsc_pkg; reads records from tsc_queue

module tsc_back
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] src_addr,
   input  logic [31:0] dst_addr,
   input  logic        q_not_empty,
   input  seg_rec_type q_rec,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_destination_port,
   output logic [31:0] rsp_seq_number,
   output logic [31:0] rsp_ack_number,
   output logic [3:0]  rsp_offset_words,
   output logic [7:0]  rsp_flag_bits,
   output logic [15:0] rsp_window,
   output logic [15:0] rsp_received_checksum,
   output logic [5:0]  rsp_header_bytes,
   output logic [15:0] rsp_payload_bytes
);

   logic             valid_ff;
   logic [1:0]       status_ff, status_in;
   seg_rec_type      rec_ff;
   logic [5:0]       hdr_ff, hdr_in;
   logic [15:0]      pay_ff, pay_in;

   logic [18:0]      total;
   logic [16:0]      fold1;
   logic [15:0]      fold2;
   logic             cks_good;
   logic             malformed;
   logic [CNT_W-1:0] hdr_wide;
   logic [CNT_W-1:0] pay_wide;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   // plain sum of all words, folded twice for the end-around carry
   always_comb begin
      total = {3'b000, q_rec.data_sum} + {3'b000, q_rec.length[15:0]}
            + {3'b000, src_addr[31:16]} + {3'b000, src_addr[15:0]}
            + {3'b000, dst_addr[31:16]} + {3'b000, dst_addr[15:0]}
            + {3'b000, IP_PROTO_TCP};
      fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
      fold2 = fold1[15:0] + {15'd0, fold1[16]};
      cks_good = (total != 19'd0) && ((fold2 == 16'h0000) || (fold2 == 16'hFFFF));
   end

   // length checks and status priority
   always_comb begin
      hdr_in    = {q_rec.offset_words, 2'b00};
      hdr_wide  = {{(CNT_W-6){1'b0}}, hdr_in};
      pay_wide  = q_rec.length - hdr_wide;
      malformed = (q_rec.length < CNT_W'(HEADER_LEN)) || (hdr_in < 6'(HEADER_LEN))
                  || (hdr_wide > q_rec.length) || q_rec.overflow;
      pay_in    = 16'h0000;
      if (malformed) begin
         status_in = STATUS_MALFORMED;
      end else if (!cks_good) begin
         status_in = STATUS_BAD_CKSUM;
      end else begin
         status_in = STATUS_OK;
         pay_in    = pay_wide[15:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff    <= q_rec;
         status_ff <= status_in;
         hdr_ff    <= hdr_in;
         pay_ff    <= pay_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_source_port       = rec_ff.source_port;
   assign rsp_destination_port  = rec_ff.destination_port;
   assign rsp_seq_number        = rec_ff.seq_number;
   assign rsp_ack_number        = rec_ff.ack_number;
   assign rsp_offset_words      = rec_ff.offset_words;
   assign rsp_flag_bits         = rec_ff.flag_bits;
   assign rsp_window            = rec_ff.window;
   assign rsp_received_checksum = rec_ff.received_checksum;
   assign rsp_header_bytes      = hdr_ff;
   assign rsp_payload_bytes     = pay_ff;

endmodule

// ----- rtl/tcp_segment_checker_core.sv -----
// tcp_segment_checker_core: top level, address registers and the parser/checker split
// depends on tsc_pkg, tsc_front, tsc_queue and tsc_back

// The block takes a TCP segment one byte per beat and returns one result beat per
// segment through the queue and then the result register. The parser does a single
// ones' complement add and a field capture per byte, and the checker folds in the
// pseudo-header and checks lengths once per segment, so back to back one-byte segments
// still sustain one byte per cycle unless the queue is full. A two-entry queue between
// parser and checker plus the result register let input keep flowing while a result
// waits; the input stalls only when both queue entries and the result are held. The
// user writes source and destination addresses via the csr port (index 0 and 1) only
// while no segment is in flight; the block does not enforce it. csr_ready is always high.

module tcp_segment_checker_core
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_destination_port,
   output logic [31:0] rsp_seq_number,
   output logic [31:0] rsp_ack_number,
   output logic [3:0]  rsp_offset_words,
   output logic [7:0]  rsp_flag_bits,
   output logic [15:0] rsp_window,
   output logic [15:0] rsp_received_checksum,
   output logic [5:0]  rsp_header_bytes,
   output logic [15:0] rsp_payload_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] src_addr_ff;
   logic [31:0] dst_addr_ff;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_not_empty;
   seg_rec_type wr_rec;
   seg_rec_type rd_rec;

   assign csr_ready = 1'b1;

   // address registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_SRC_ADDR) begin
            src_addr_ff <= csr_wdata;
         end else if (csr_index == CSR_DST_ADDR) begin
            dst_addr_ff <= csr_wdata;
         end
      end
   end

   tsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_rec         (wr_rec)
   );

   tsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_rec    (wr_rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rd_rec    (rd_rec)
   );

   tsc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .src_addr              (src_addr_ff),
      .dst_addr              (dst_addr_ff),
      .q_not_empty           (q_not_empty),
      .q_rec                 (rd_rec),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_source_port       (rsp_source_port),
      .rsp_destination_port  (rsp_destination_port),
      .rsp_seq_number        (rsp_seq_number),
      .rsp_ack_number        (rsp_ack_number),
      .rsp_offset_words      (rsp_offset_words),
      .rsp_flag_bits         (rsp_flag_bits),
      .rsp_window            (rsp_window),
      .rsp_received_checksum (rsp_received_checksum),
      .rsp_header_bytes      (rsp_header_bytes),
      .rsp_payload_bytes     (rsp_payload_bytes)
   );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for tcp_segment_checker_core, bytes in and one result beat per segment
// depends on tsc_pkg and the core; predicts header fields, lengths and status in a scoreboard class

module tb;
   import tsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT = 400000;
   localparam int          GAP_MAX     = 40;
   localparam logic [7:0]  CSR_UNUSED  = 8'hFF;

   // one result beat as the block reports it
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [3:0]  offset_words;
      logic [7:0]  flag_bits;
      logic [15:0] window;
      logic [15:0] received_checksum;
      logic [5:0]  header_bytes;
      logic [15:0] payload_bytes;
   } tcp_result_type;

   // segment predictor plus the store of expected results
   class seg_scoreboard;
      tcp_result_type expected_q[$];
      bit [31:0]   src_addr;
      bit [31:0]   dst_addr;
      bit [16:0]   byte_cnt;
      bit [15:0]   sum_acc;
      bit [7:0]    high_byte;
      bit [15:0]   sport;
      bit [15:0]   dport;
      bit [31:0]   seq;
      bit [31:0]   ack;
      bit [3:0]    offs;
      bit [7:0]    flags;
      bit [15:0]   win;
      bit [15:0]   cks;
      bit          ovf;
      int          errors;

      static function bit [15:0] ones_add(bit [15:0] a, bit [15:0] w);
         bit [16:0] t;
         t = {1'b0, a} + {1'b0, w};
         return t[16] ? t[15:0] + 16'd1 : t[15:0];
      endfunction

      function void clear_segment();
         byte_cnt  = '0;
         sum_acc   = '0;
         high_byte = '0;
         sport     = '0;
         dport     = '0;
         seq       = '0;
         ack       = '0;
         offs      = '0;
         flags     = '0;
         win       = '0;
         cks       = '0;
         ovf       = 1'b0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [31:0] data);
         if (idx == CSR_SRC_ADDR) begin
            src_addr = data;
         end else if (idx == CSR_DST_ADDR) begin
            dst_addr = data;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one accepted byte: capture, sum, count, and on the last byte the verdict
      function void note_byte(logic [7:0] b, logic last);
         int unsigned pos;
         int unsigned len;
         int unsigned hdr;
         bit          odd;
         bit [15:0]   s;
         tcp_result_type r;
         pos = 32'(byte_cnt);
         odd = byte_cnt[0];
         case (pos)
            0, 1:          sport = {sport[7:0], b};
            2, 3:          dport = {dport[7:0], b};
            4, 5, 6, 7:    seq   = {seq[23:0], b};
            8, 9, 10, 11:  ack   = {ack[23:0], b};
            12:            offs  = b[7:4];
            13:            flags = b;
            14, 15:        win   = {win[7:0], b};
            16, 17:        cks   = {cks[7:0], b};
            default: ;
         endcase
         if (odd) begin
            sum_acc = ones_add(sum_acc, {high_byte, b});
         end else begin
            high_byte = b;
         end
         // count saturates one past the largest legal length
         if (byte_cnt >= COUNT_MAX_M1) begin
            if (byte_cnt == COUNT_MAX) ovf = 1'b1;
            byte_cnt = COUNT_MAX;
         end else begin
            byte_cnt = byte_cnt + 17'd1;
         end
         if (byte_cnt == COUNT_MAX) ovf = 1'b1;
         if (!last) return;

         // pad an odd final byte, then fold in the pseudo-header
         len = 32'(byte_cnt);
         s = sum_acc;
         if (!odd) s = ones_add(s, {b, 8'h00});
         s = ones_add(s, src_addr[31:16]);
         s = ones_add(s, src_addr[15:0]);
         s = ones_add(s, dst_addr[31:16]);
         s = ones_add(s, dst_addr[15:0]);
         s = ones_add(s, IP_PROTO_TCP);
         s = ones_add(s, byte_cnt[15:0]);

         hdr = offs * 4;
         r.payload_bytes = '0;
         if (len < HEADER_LEN || hdr < HEADER_LEN || hdr > len || ovf) begin
            r.status = STATUS_MALFORMED;
         end else if (s != 16'hFFFF) begin
            r.status = STATUS_BAD_CKSUM;
         end else begin
            r.status = STATUS_OK;
            r.payload_bytes = 16'(len - hdr);
         end
         r.source_port       = sport;
         r.destination_port  = dport;
         r.seq_number        = seq;
         r.ack_number        = ack;
         r.offset_words      = offs;
         r.flag_bits         = flags;
         r.window            = win;
         r.received_checksum = cks;
         r.header_bytes      = 6'(hdr);
         expected_q.push_back(r);
         clear_segment();
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
      endfunction

      // one accepted result beat against the oldest expectation
      function void check_result(tcp_result_type got);
         tcp_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result beat with nothing expected: %h", got);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report("status", 32'(want.status), 32'(got.status));
         if (got.source_port !== want.source_port)
            report("source_port", 32'(want.source_port), 32'(got.source_port));
         if (got.destination_port !== want.destination_port)
            report("destination_port", 32'(want.destination_port),
                   32'(got.destination_port));
         if (got.seq_number !== want.seq_number)
            report("seq_number", want.seq_number, got.seq_number);
         if (got.ack_number !== want.ack_number)
            report("ack_number", want.ack_number, got.ack_number);
         if (got.offset_words !== want.offset_words)
            report("offset_words", 32'(want.offset_words), 32'(got.offset_words));
         if (got.flag_bits !== want.flag_bits)
            report("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
         if (got.window !== want.window)
            report("window", 32'(want.window), 32'(got.window));
         if (got.received_checksum !== want.received_checksum)
            report("received_checksum", 32'(want.received_checksum),
                   32'(got.received_checksum));
         if (got.header_bytes !== want.header_bytes)
            report("header_bytes", 32'(want.header_bytes), 32'(got.header_bytes));
         if (got.payload_bytes !== want.payload_bytes)
            report("payload_bytes", 32'(want.payload_bytes), 32'(got.payload_bytes));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_destination_port;
   logic [31:0] rsp_seq_number;
   logic [31:0] rsp_ack_number;
   logic [3:0]  rsp_offset_words;
   logic [7:0]  rsp_flag_bits;
   logic [15:0] rsp_window;
   logic [15:0] rsp_received_checksum;
   logic [5:0]  rsp_header_bytes;
   logic [15:0] rsp_payload_bytes;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;

   seg_scoreboard sb;
   logic [7:0]    seg_q[$];
   int            tx_pct;
   int            rx_pct;
   int            stall_run;
   int            cycles;

   tcp_segment_checker_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_source_port       (rsp_source_port),
      .rsp_destination_port  (rsp_destination_port),
      .rsp_seq_number        (rsp_seq_number),
      .rsp_ack_number        (rsp_ack_number),
      .rsp_offset_words      (rsp_offset_words),
      .rsp_flag_bits         (rsp_flag_bits),
      .rsp_window            (rsp_window),
      .rsp_received_checksum (rsp_received_checksum),
      .rsp_header_bytes      (rsp_header_bytes),
      .rsp_payload_bytes     (rsp_payload_bytes),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // result side back-pressure, capped stall runs
   always @(negedge clock) begin
      if (stall_run < GAP_MAX && $urandom_range(99) < rx_pct) begin
         rsp_ready <= 1'b0;
         stall_run++;
      end else begin
         rsp_ready <= 1'b1;
         stall_run = 0;
      end
   end

   // result beat monitor
   always @(posedge clock) begin
      tcp_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status            = rsp_status;
         got.source_port       = rsp_source_port;
         got.destination_port  = rsp_destination_port;
         got.seq_number        = rsp_seq_number;
         got.ack_number        = rsp_ack_number;
         got.offset_words      = rsp_offset_words;
         got.flag_bits         = rsp_flag_bits;
         got.window            = rsp_window;
         got.received_checksum = rsp_received_checksum;
         got.header_bytes      = rsp_header_bytes;
         got.payload_bytes     = rsp_payload_bytes;
         sb.check_result(got);
      end
   end

   // ones' complement sum of pseudo-header and the segment being built
   function automatic bit [15:0] segment_sum();
      bit [15:0] s;
      bit [7:0]  lo;
      int        n;
      s = '0;
      n = seg_q.size();
      for (int i = 0; i < n; i += 2) begin
         lo = (i + 1 < n) ? seg_q[i+1] : 8'h00;
         s = seg_scoreboard::ones_add(s, {seg_q[i], lo});
      end
      s = seg_scoreboard::ones_add(s, sb.src_addr[31:16]);
      s = seg_scoreboard::ones_add(s, sb.src_addr[15:0]);
      s = seg_scoreboard::ones_add(s, sb.dst_addr[31:16]);
      s = seg_scoreboard::ones_add(s, sb.dst_addr[15:0]);
      s = seg_scoreboard::ones_add(s, IP_PROTO_TCP);
      s = seg_scoreboard::ones_add(s, 16'(n));
      return s;
   endfunction

   // fill the segment; fill < 0 means random bytes, fix sets a matching checksum
   function automatic void build_seg(int off, int len, bit fix, int fill);
      bit [15:0] s;
      seg_q.delete();
      for (int i = 0; i < len; i++) begin
         seg_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      end
      if (len > 12) seg_q[12] = {4'(off), seg_q[12][3:0]};
      if (fix && len >= 18) begin
         seg_q[16] = 8'h00;
         seg_q[17] = 8'h00;
         s = ~segment_sum();
         seg_q[16] = s[15:8];
         seg_q[17] = s[7:0];
      end
   endfunction

   function automatic void corrupt_seg();
      int idx;
      idx = $urandom_range(seg_q.size() - 1);
      seg_q[idx] = seg_q[idx] ^ (8'h01 << $urandom_range(7));
   endfunction

   // one byte beat, called and returning at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(99) < tx_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_seg();
      int n;
      n = seg_q.size();
      for (int i = 0; i < n; i++) send_byte(seg_q[i], i == n - 1);
   endtask

   // hold the sender until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // idle block, then new addresses and idling mix
   task automatic set_phase(input logic [31:0] src, input logic [31:0] dst, input int tx,
                            input int rx);
      drain();
      repeat (8) @(negedge clock);
      csr_write(CSR_SRC_ADDR, src);
      csr_write(CSR_DST_ADDR, dst);
      csr_valid <= 1'b0;
      tx_pct = tx;
      rx_pct = rx;
   endtask

   // mostly well-formed segments with random content, the rest broken or noise
   task automatic run_random(input int goal);
      int sent;
      int kind;
      int off;
      int len;
      sent = 0;
      while (sent < goal) begin
         kind = $urandom_range(99);
         off = $urandom_range(1) ? 5 : $urandom_range(5, 15);
         if (kind < 70) begin
            len = off * 4 + $urandom_range(24);
            build_seg(off, len, 1'b1, -1);
            if (kind >= 60) corrupt_seg();
         end else if (kind < 80) begin
            build_seg($urandom_range(15), $urandom_range(1, 19), 1'b0, -1);
         end else if (kind < 90) begin
            if ($urandom_range(1)) begin
               off = $urandom_range(4);
               len = 20 + $urandom_range(20);
            end else begin
               off = $urandom_range(6, 15);
               len = 20 + $urandom_range(off * 4 - 21);
            end
            build_seg(off, len, 1'b1, -1);
         end else begin
            build_seg($urandom_range(15), $urandom_range(1, 80), 1'b0, -1);
         end
         send_seg();
         sent += seg_q.size();
         if ($urandom_range(19) == 0) drain();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      tx_pct        = 0;
      rx_pct        = 0;
      sb = new;
      sb.clear_segment();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // directed, reset addresses: extremes, odd length, bad checksum, bad offsets, short
      build_seg(5, 20, 1'b1, 8'h00);  send_seg();
      build_seg(5, 21, 1'b1, -1);     send_seg();
      build_seg(15, 60, 1'b1, 8'hFF); send_seg();
      build_seg(5, 40, 1'b1, -1);
      seg_q[18] = seg_q[18] ^ 8'h01;  // urgent pointer is summed
      send_seg();
      build_seg(0, 20, 1'b1, -1);     send_seg();
      build_seg(4, 24, 1'b1, -1);     send_seg();
      build_seg(15, 59, 1'b1, -1);    send_seg();
      build_seg(5, 1, 1'b0, 8'hFF);   send_seg();
      build_seg(5, 19, 1'b0, -1);     send_seg();
      build_seg(5, 13, 1'b0, -1);     send_seg();

      // all-ones addresses and an ignored index
      drain();
      repeat (8) @(negedge clock);
      csr_write(CSR_SRC_ADDR, 32'hFFFF_FFFF);
      csr_write(CSR_DST_ADDR, 32'hFFFF_FFFF);
      csr_write(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      build_seg(5, 20, 1'b1, 8'hFF);  send_seg();
      build_seg(6, 33, 1'b1, -1);     send_seg();

      set_phase($urandom, $urandom, 0, 0);
      run_random(300);
      set_phase(32'h0000_0000, 32'hFFFF_FFFF, 88, 0);
      run_random(300);
      set_phase(32'hFFFF_FFFF, $urandom, 0, 88);
      run_random(300);
      set_phase($urandom, $urandom, 32, 32);
      run_random(300);

      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ----- tcp_segment_checker_core.f -----
rtl/tsc_pkg.sv
rtl/tsc_front.sv
rtl/tsc_queue.sv
rtl/tsc_back.sv
rtl/tcp_segment_checker_core.sv
tb/tb.sv
